[rtl/c2sv_pkg.sv]
`default_nettype none

package c2sv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

[rtl/c2sv_sqrt.sv]
`default_nettype none

module c2sv_sqrt import c2sv_pkg::*; #(
  parameter int RADW = 2 * DATA_WIDTH_DEF + 2,
  localparam int STEPS = RADW / 2,
  localparam int RW = STEPS + 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [RADW-1:0]  radicand,
  output logic [STEPS-1:0] root
);

  logic [RADW-1:0]  rad_q  [STEPS];
  logic [RW-1:0]    rem_q  [STEPS];
  logic [STEPS-1:0] root_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RADW-1:0]  rad_in;
    logic [RW-1:0]    rem_in;
    logic [STEPS-1:0] root_in;
    logic [RW+1:0]    cat;
    logic [RW+1:0]    sub;

    if (k == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign cat = {rem_in, rad_in[RADW-1 -: 2]};
    assign sub = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k] <= rad_in << 2;
        if (cat >= sub) begin
          rem_q[k]  <= RW'(cat - sub);
          root_q[k] <= {root_in[STEPS-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cat[RW-1:0];
          root_q[k] <= {root_in[STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[STEPS-1];

endmodule

`default_nettype wire

[rtl/c2sv_front.sv]
`default_nettype none

module c2sv_front import c2sv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int DW = DATA_WIDTH,
  localparam int NW = 3 * DATA_WIDTH + 2,
  localparam int DENW = 2 * DATA_WIDTH + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [DW-1:0]   pos_x,
  input  logic signed [DW-1:0]   pos_y,
  input  logic signed [DW-1:0]   pos_z,
  input  logic signed [DW-1:0]   vec_x,
  input  logic signed [DW-1:0]   vec_y,
  input  logic signed [DW-1:0]   vec_z,
  output logic                   out_valid,
  output logic                   out_zero,
  output logic signed [NW-1:0]   num_r,
  output logic signed [NW-1:0]   num_t,
  output logic signed [NW-1:0]   num_p,
  output logic [DENW-1:0]        den_r,
  output logic [DENW-1:0]        den_t,
  output logic [DENW-1:0]        den_p
);

  localparam int RADW = 2 * DW + 2;
  localparam int STEPS = RADW / 2;
  localparam int TW = 3 * DW;
  localparam int T2W = 3 * DW + 3;
  localparam int PW = 2 * (2 * DW + 1) + (2 * DW + 2) + 2 * DW + 1;

  // Products of the coordinates.
  logic                   v1;
  logic signed [2*DW-1:0] sq_x, sq_y, sq_z;
  logic signed [2*DW-1:0] p_xux, p_yuy, p_zuz, p_xuy, p_yux;
  logic signed [DW-1:0]   z1, uz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x  <= pos_x * pos_x;
      sq_y  <= pos_y * pos_y;
      sq_z  <= pos_z * pos_z;
      p_xux <= pos_x * vec_x;
      p_yuy <= pos_y * vec_y;
      p_zuz <= pos_z * vec_z;
      p_xuy <= pos_x * vec_y;
      p_yux <= pos_y * vec_x;
      z1    <= pos_z;
      uz1   <= vec_z;
    end
  end

  // Sums of squares and the numerators that need no root.
  logic                   v2;
  logic [RADW-1:0]        hsq, rsq;
  logic signed [2*DW:0]   s2, p2;
  logic signed [2*DW+1:0] nr2;
  logic signed [DW-1:0]   z2, uz2;
  logic                   zero2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsq   <= RADW'($unsigned(sq_x)) + RADW'($unsigned(sq_y));
      rsq   <= RADW'($unsigned(sq_x)) + RADW'($unsigned(sq_y)) + RADW'($unsigned(sq_z));
      s2    <= (2*DW+1)'(p_xux) + (2*DW+1)'(p_yuy);
      p2    <= (2*DW+1)'(p_xuy) - (2*DW+1)'(p_yux);
      nr2   <= RADW'(p_xux) + RADW'(p_yuy) + RADW'(p_zuz);
      z2    <= z1;
      uz2   <= uz1;
      zero2 <= (sq_x == '0) && (sq_y == '0) && (sq_z == '0);
    end
  end

  // Both roots, with the remaining fields delayed alongside.
  logic [STEPS-1:0] root_r, root_h;

  c2sv_sqrt #(.RADW(RADW)) u_sqrt_r (
    .clk      (clk),
    .en       (en),
    .radicand (rsq),
    .root     (root_r)
  );

  c2sv_sqrt #(.RADW(RADW)) u_sqrt_h (
    .clk      (clk),
    .en       (en),
    .radicand (hsq),
    .root     (root_h)
  );

  logic [PW-1:0]    dly [STEPS];
  logic [STEPS-1:0] dly_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_v <= '0;
    end else if (en) begin
      dly_v <= {dly_v[STEPS-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= {s2, p2, nr2, z2, uz2, zero2};
      for (int k = 1; k < STEPS; k++) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  logic signed [2*DW:0]   d_s, d_p;
  logic signed [2*DW+1:0] d_nr;
  logic signed [DW-1:0]   d_z, d_uz;
  logic                   d_zero;

  assign {d_s, d_p, d_nr, d_z, d_uz, d_zero} = dly[STEPS-1];

  // First products on the roots.
  logic [DW:0]     xy_c;
  logic [DW-1:0]   az_c, auz_c;
  logic [2*DW:0]   s_abs_full;
  logic [2*DW-1:0] as_c;
  logic [2*DW+1:0] dt_full;

  always_comb begin
    xy_c       = (root_h == '0) ? (DW+1)'(1) : root_h;
    az_c       = d_z[DW-1] ? -d_z : d_z;
    auz_c      = d_uz[DW-1] ? -d_uz : d_uz;
    s_abs_full = d_s[2*DW] ? -d_s : d_s;
    as_c       = s_abs_full[2*DW-1:0];
    dt_full    = xy_c * root_r;
  end

  logic                   vm1, zero_m1, sz_neg1, uz_neg1;
  logic [2*DW:0]          a1;
  logic [2*DW-1:0]        sl1, sh1;
  logic [DENW-1:0]        dt1;
  logic [DW:0]            xy1, r1;
  logic signed [2*DW+1:0] nr_m1;
  logic signed [2*DW:0]   p_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
    end else if (en) begin
      vm1 <= dly_v[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1      <= xy_c * auz_c;
      sl1     <= as_c[DW-1:0] * az_c;
      sh1     <= as_c[2*DW-1:DW] * az_c;
      dt1     <= dt_full[DENW-1:0];
      xy1     <= xy_c;
      r1      <= root_r;
      nr_m1   <= d_nr;
      p_m1    <= d_p;
      zero_m1 <= d_zero;
      sz_neg1 <= d_s[2*DW] ^ d_z[DW-1];
      uz_neg1 <= d_uz[DW-1];
    end
  end

  // Partial products of both theta terms.
  logic                   vm2, zero_m2, sz_neg2, uz_neg2;
  logic [TW-1:0]          t1_2;
  logic [2*DW:0]          a_lo2;
  logic [2*DW+1:0]        a_hi2;
  logic [DENW-1:0]        dt2;
  logic [DW:0]            xy2, r2;
  logic signed [2*DW+1:0] nr_m2;
  logic signed [2*DW:0]   p_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm2 <= 1'b0;
    end else if (en) begin
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_2    <= {sh1, {DW{1'b0}}} + {{DW{1'b0}}, sl1};
      a_lo2   <= a1[DW-1:0] * xy1;
      a_hi2   <= a1[2*DW:DW] * xy1;
      dt2     <= dt1;
      xy2     <= xy1;
      r2      <= r1;
      nr_m2   <= nr_m1;
      p_m2    <= p_m1;
      zero_m2 <= zero_m1;
      sz_neg2 <= sz_neg1;
      uz_neg2 <= uz_neg1;
    end
  end

  logic [T2W-1:0] t2_full;
  logic [NW-1:0]  t1e;

  always_comb begin
    t2_full = {1'b0, a_hi2, {DW{1'b0}}} + T2W'(a_lo2);
    t1e     = {2'b00, t1_2};
  end

  logic                   vm3, zero_m3, uz_neg3;
  logic [TW-1:0]          t2_3;
  logic signed [NW-1:0]   t1s3;
  logic [DENW-1:0]        dt3;
  logic [DW:0]            xy3, r3;
  logic signed [2*DW+1:0] nr_m3;
  logic signed [2*DW:0]   p_m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm3 <= 1'b0;
    end else if (en) begin
      vm3 <= vm2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_3    <= t2_full[TW-1:0];
      t1s3    <= sz_neg2 ? -t1e : t1e;
      dt3     <= dt2;
      xy3     <= xy2;
      r3      <= r2;
      nr_m3   <= nr_m2;
      p_m3    <= p_m2;
      zero_m3 <= zero_m2;
      uz_neg3 <= uz_neg2;
    end
  end

  logic [NW-1:0] t2e;

  assign t2e = {2'b00, t2_3};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vm3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_t    <= uz_neg3 ? t1s3 + $signed(t2e) : t1s3 - $signed(t2e);
      num_r    <= NW'(nr_m3);
      num_p    <= NW'(p_m3);
      den_r    <= DENW'(r3);
      den_t    <= dt3;
      den_p    <= DENW'(xy3);
      out_zero <= zero_m3;
    end
  end

endmodule

`default_nettype wire

[rtl/c2sv_queue.sv]
`default_nettype none

module c2sv_queue import c2sv_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             nonempty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr, wr_ptr_next, rd_ptr_next;
  logic [CW-1:0]    count, count_next;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata    = mem[rd_ptr];
  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);

endmodule

`default_nettype wire

[rtl/c2sv_div.sv]
`default_nettype none

module c2sv_div import c2sv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int DW = DATA_WIDTH,
  localparam int NW = 3 * DATA_WIDTH + 2,
  localparam int DENW = 2 * DATA_WIDTH + 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic [DENW-1:0]      den,
  output logic signed [DW-1:0] quo,
  output logic                 sat
);

  // Magnitude, sign and the check for a quotient of more than DW bits.
  logic [NW-1:0] mag, dshift, upper;

  always_comb begin
    mag    = num[NW-1] ? -num : num;
    dshift = '0;
    dshift[DENW+DW-1:DW] = den;
    upper  = mag >> DW;
  end

  logic [DENW-1:0] p_rem, p_den;
  logic [DW-1:0]   p_lo;
  logic            p_neg, p_ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      p_rem <= upper[DENW-1:0];
      p_lo  <= mag[DW-1:0];
      p_den <= den;
      p_neg <= num[NW-1];
      p_ovf <= (mag >= dshift);
    end
  end

  // One quotient bit per stage, restoring.
  logic [DENW-1:0] s_rem [DW];
  logic [DENW-1:0] s_den [DW];
  logic [DW-1:0]   s_lo  [DW];
  logic [DW-1:0]   s_q   [DW];
  logic [DW-1:0]   s_neg, s_ovf;

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [DENW-1:0] rem_in, den_in;
    logic [DW-1:0]   lo_in, q_in;
    logic            neg_in, ovf_in;
    logic [DENW:0]   remsh, den_x;

    if (k == 0) begin : g_first
      assign rem_in = p_rem;
      assign den_in = p_den;
      assign lo_in  = p_lo;
      assign q_in   = '0;
      assign neg_in = p_neg;
      assign ovf_in = p_ovf;
    end else begin : g_rest
      assign rem_in = s_rem[k-1];
      assign den_in = s_den[k-1];
      assign lo_in  = s_lo[k-1];
      assign q_in   = s_q[k-1];
      assign neg_in = s_neg[k-1];
      assign ovf_in = s_ovf[k-1];
    end

    assign remsh = {rem_in, lo_in[DW-1]};
    assign den_x = {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        s_lo[k]  <= lo_in << 1;
        s_den[k] <= den_in;
        s_neg[k] <= neg_in;
        s_ovf[k] <= ovf_in;
        if (remsh >= den_x) begin
          s_rem[k] <= DENW'(remsh - den_x);
          s_q[k]   <= {q_in[DW-2:0], 1'b1};
        end else begin
          s_rem[k] <= remsh[DENW-1:0];
          s_q[k]   <= {q_in[DW-2:0], 1'b0};
        end
      end
    end
  end

  // Round half away from zero.
  logic [DW:0] f_q;
  logic        f_neg, f_ovf;
  logic        rnd;

  assign rnd = ({s_rem[DW-1], 1'b0} >= {1'b0, s_den[DW-1]});

  always_ff @(posedge clk) begin
    if (en) begin
      f_q   <= {1'b0, s_q[DW-1]} + (DW+1)'(rnd);
      f_neg <= s_neg[DW-1];
      f_ovf <= s_ovf[DW-1];
    end
  end

  // Clip to the signed range and apply the sign.
  logic [DW:0] lim, mag_o, res;
  logic        clip;

  always_comb begin
    lim   = ((DW+1)'(1) << (DW - 1)) - (f_neg ? (DW+1)'(0) : (DW+1)'(1));
    clip  = f_ovf || (f_q > lim);
    mag_o = clip ? lim : f_q;
    res   = f_neg ? (~mag_o + 1'b1) : mag_o;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= res[DW-1:0];
      sat <= clip;
    end
  end

endmodule

`default_nettype wire

[rtl/c2sv_back.sv]
`default_nettype none

module c2sv_back import c2sv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int DW = DATA_WIDTH,
  localparam int NW = 3 * DATA_WIDTH + 2,
  localparam int DENW = 2 * DATA_WIDTH + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_zero,
  input  logic signed [NW-1:0] num_r,
  input  logic signed [NW-1:0] num_t,
  input  logic signed [NW-1:0] num_p,
  input  logic [DENW-1:0]      den_r,
  input  logic [DENW-1:0]      den_t,
  input  logic [DENW-1:0]      den_p,
  output logic                 out_valid,
  output logic signed [DW-1:0] radial,
  output logic signed [DW-1:0] colatitude_part,
  output logic signed [DW-1:0] longitude_part,
  output logic                 zero_radius,
  output logic                 saturated
);

  localparam int LAT = DW + 3;

  logic signed [DW-1:0] q_r, q_t, q_p;
  logic                 sat_r, sat_t, sat_p;

  c2sv_div #(.DATA_WIDTH(DW)) u_div_r (
    .clk (clk), .en (en), .num (num_r), .den (den_r), .quo (q_r), .sat (sat_r)
  );

  c2sv_div #(.DATA_WIDTH(DW)) u_div_t (
    .clk (clk), .en (en), .num (num_t), .den (den_t), .quo (q_t), .sat (sat_t)
  );

  c2sv_div #(.DATA_WIDTH(DW)) u_div_p (
    .clk (clk), .en (en), .num (num_p), .den (den_p), .quo (q_p), .sat (sat_p)
  );

  logic [LAT-1:0] dv, dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (en) begin
      dv <= {dv[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz <= {dz[LAT-2:0], in_zero};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radial          <= dz[LAT-1] ? '0 : q_r;
      colatitude_part <= dz[LAT-1] ? '0 : q_t;
      longitude_part  <= dz[LAT-1] ? '0 : q_p;
      zero_radius     <= dz[LAT-1];
      saturated       <= !dz[LAT-1] && (sat_r || sat_t || sat_p);
    end
  end

endmodule

`default_nettype wire

[rtl/cartesian_to_spherical_vector.sv]
// Cartesian to spherical vector rotation.
// The item channel (item_valid, item_stall) carries a point pos_x/y/z and a
// vector vec_x/y/z; the result channel (result_valid, result_stall) carries
// the radial, colatitude and longitude components, all signed fixed point,
// with the zero_radius and saturated flags. A transfer takes place at a
// rising edge where valid is high and stall is low.
// One item is accepted per cycle while item_stall is low. The front pipeline
// (products, two digit-by-digit square roots and the theta products) writes
// each item into the queue, from which it enters the back pipeline. The
// back pipeline (three restoring dividers, one quotient bit per stage, then
// rounding and clipping) offers the result on the result channel.
// When the receiver stalls, the back pipeline holds its results and the
// front keeps accepting items until the queue between them is full; then
// item_stall is raised. Reset empties both pipelines and the queue; no
// item is lost once accepted.
`default_nettype none

module cartesian_to_spherical_vector import c2sv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic signed [DATA_WIDTH-1:0] pos_x,
  input  logic signed [DATA_WIDTH-1:0] pos_y,
  input  logic signed [DATA_WIDTH-1:0] pos_z,
  input  logic signed [DATA_WIDTH-1:0] vec_x,
  input  logic signed [DATA_WIDTH-1:0] vec_y,
  input  logic signed [DATA_WIDTH-1:0] vec_z,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [DATA_WIDTH-1:0] radial,
  output logic signed [DATA_WIDTH-1:0] colatitude_part,
  output logic signed [DATA_WIDTH-1:0] longitude_part,
  output logic                         zero_radius,
  output logic                         saturated
);

  localparam int NW = 3 * DATA_WIDTH + 2;
  localparam int DENW = 2 * DATA_WIDTH + 1;
  localparam int QW = 1 + 3 * NW + 3 * DENW;
  localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                 front_en, back_en;
  logic                 f_valid, f_zero;
  logic signed [NW-1:0] f_num_r, f_num_t, f_num_p;
  logic [DENW-1:0]      f_den_r, f_den_t, f_den_p;
  logic                 q_full, q_nonempty, push, pop;
  logic [QW-1:0]        q_wdata, q_rdata;
  logic                 b_zero;
  logic signed [NW-1:0] b_num_r, b_num_t, b_num_p;
  logic [DENW-1:0]      b_den_r, b_den_t, b_den_p;

  assign front_en   = !(f_valid && q_full);
  assign item_stall = !front_en;
  assign push       = f_valid && front_en;
  assign back_en    = !result_valid || !result_stall;
  assign pop        = q_nonempty && back_en;

  c2sv_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (front_en),
    .in_valid  (item_valid),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .out_valid (f_valid),
    .out_zero  (f_zero),
    .num_r     (f_num_r),
    .num_t     (f_num_t),
    .num_p     (f_num_p),
    .den_r     (f_den_r),
    .den_t     (f_den_t),
    .den_p     (f_den_p)
  );

  assign q_wdata = {f_zero, f_num_r, f_num_t, f_num_p, f_den_r, f_den_t, f_den_p};

  c2sv_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (q_wdata),
    .pop      (pop),
    .rdata    (q_rdata),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  assign {b_zero, b_num_r, b_num_t, b_num_p, b_den_r, b_den_t, b_den_p} = q_rdata;

  c2sv_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk             (clk),
    .rst             (rst),
    .en              (back_en),
    .in_valid        (pop),
    .in_zero         (b_zero),
    .num_r           (b_num_r),
    .num_t           (b_num_t),
    .num_p           (b_num_p),
    .den_r           (b_den_r),
    .den_t           (b_den_t),
    .den_p           (b_den_p),
    .out_valid       (result_valid),
    .radial          (radial),
    .colatitude_part (colatitude_part),
    .longitude_part  (longitude_part),
    .zero_radius     (zero_radius),
    .saturated       (saturated)
  );

  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_radius |-> radial == '0 && colatitude_part == '0 &&
      longitude_part == '0 && !saturated)
    else $error("Origin result carries non-zero components.");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> radial == SMAX || radial == SMIN ||
      colatitude_part == SMAX || colatitude_part == SMIN ||
      longitude_part == SMAX || longitude_part == SMIN)
    else $error("Saturation flag set with no component at a limit.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> f_valid && q_full)
    else $error("Item channel stalled without a full queue.");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("Queue written while full.");

endmodule

`default_nettype wire

[tb/sv/c2sv_result_checker.sv]
`timescale 1ns / 100ps

module c2sv_result_checker import c2sv_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  logic signed [W-1:0] pos_x,
  input  logic signed [W-1:0] pos_y,
  input  logic signed [W-1:0] pos_z,
  input  logic signed [W-1:0] vec_x,
  input  logic signed [W-1:0] vec_y,
  input  logic signed [W-1:0] vec_z,
  input  logic                result_valid,
  input  logic                result_stall,
  input  logic signed [W-1:0] radial,
  input  logic signed [W-1:0] colatitude_part,
  input  logic signed [W-1:0] longitude_part,
  input  logic                zero_radius,
  input  logic                saturated,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [W-1:0] radial;
    logic [W-1:0] colatitude;
    logic [W-1:0] longitude;
    logic         zero_radius;
    logic         saturated;
  } rotated_t;

  rotated_t rotated_q[$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [W-1:0] rounded_quotient(input logic signed [127:0] num,
                                                    input logic [127:0] den,
                                                    inout logic sat);
    logic         neg;
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] rem;
    logic [127:0] limit;
    logic [127:0] res;
    neg = num < 0;
    mag = neg ? -num : num;
    if (den == 0) den = 1;
    q = mag / den;
    rem = mag % den;
    if (rem >= den - rem) q = q + 1;
    limit = (128'd1 << (W - 1)) - (neg ? 128'd0 : 128'd1);
    if (q > limit) begin
      sat = 1'b1;
      q = limit;
    end
    res = neg ? -q : q;
    return res[W-1:0];
  endfunction

  function automatic rotated_t rotate_vector(input logic signed [W-1:0] x, y, z, ux, uy, uz);
    logic signed [127:0] xw, yw, zw, uxw, uyw, uzw, hw, dot_xy;
    logic [127:0]        hsq, rsq;
    logic [63:0]         rad, hrad;
    logic                sat;
    rotated_t            o;
    xw = x; yw = y; zw = z; uxw = ux; uyw = uy; uzw = uz;
    hsq = xw * xw + yw * yw;
    rsq = hsq + zw * zw;
    o = '0;
    if (rsq == 0) begin
      o.zero_radius = 1'b1;
      return o;
    end
    rad = floor_sqrt(rsq[63:0]);
    hrad = floor_sqrt(hsq[63:0]);
    if (hrad < 1) hrad = 1;
    hw = {64'd0, hrad};
    sat = 1'b0;
    dot_xy = xw * uxw + yw * uyw;
    o.radial = rounded_quotient(dot_xy + zw * uzw, {64'd0, rad}, sat);
    o.colatitude = rounded_quotient(dot_xy * zw - hw * hw * uzw,
                                    {64'd0, hrad} * {64'd0, rad}, sat);
    o.longitude = rounded_quotient(xw * uyw - yw * uxw, {64'd0, hrad}, sat);
    o.saturated = sat;
    return o;
  endfunction

  always @(posedge clk) begin
    rotated_t want;
    if (rst) begin
      rotated_q.delete();
      fail_count <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = rotated_q.pop_front();
          if (radial !== want.radial ||
              colatitude_part !== want.colatitude ||
              longitude_part !== want.longitude ||
              zero_radius !== want.zero_radius ||
              saturated !== want.saturated) begin
            $display("%0t: expected r=%h t=%h p=%h z=%b s=%b, got r=%h t=%h p=%h z=%b s=%b",
                     $time, want.radial, want.colatitude, want.longitude,
                     want.zero_radius, want.saturated, radial, colatitude_part,
                     longitude_part, zero_radius, saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (item_valid && !item_stall)
        rotated_q.insert(rotated_q.size(),
                         rotate_vector(pos_x, pos_y, pos_z, vec_x, vec_y, vec_z));
    end
    pending <= rotated_q.size();
  end

endmodule

[tb/sv/tb_cartesian_to_spherical_vector.sv]
`timescale 1ns / 100ps

module tb_cartesian_to_spherical_vector;
  import c2sv_pkg::*;

  localparam int W = DATA_WIDTH_DEF;
  localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  logic signed [W-1:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [W-1:0] vec_x = 0, vec_y = 0, vec_z = 0;
  logic result_valid;
  logic result_stall = 0;
  logic signed [W-1:0] radial, colatitude_part, longitude_part;
  logic zero_radius, saturated;
  int fail_count, pending;
  int cycles = 0;
  logic calm = 0;

  always #5 clk = ~clk;

  cartesian_to_spherical_vector i_dut (.*);

  c2sv_result_checker #(.W(W)) i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    result_stall <= !calm && ($urandom_range(0, 99) < 10);
    if (cycles > CYCLE_LIMIT) begin
      $display("cartesian_to_spherical_vector regression: fail");
      $finish;
    end
  end

  task automatic send_point(input logic signed [W-1:0] x, y, z, ux, uy, uz);
    logic taken;
    item_valid <= 1'b1;
    pos_x <= x; pos_y <= y; pos_z <= z;
    vec_x <= ux; vec_y <= uy; vec_z <= uz;
    do begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end while (!taken);
    if (!calm && $urandom_range(0, 99) < 10) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic signed [W-1:0] pick_value(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 * 65536 * 16)) - 65536 * 16;
      2: return $signed($urandom_range(0, 200)) - 100;
      3: return $urandom_range(0, 1) ? MAX_V : MIN_V;
      default: return $signed($urandom_range(0, 2 * 65536 * 1000)) - 65536 * 1000;
    endcase
  endfunction

  task automatic send_random;
    int kind;
    logic signed [W-1:0] x, y;
    kind = $urandom_range(0, 9);
    x = pick_value(kind % 5);
    y = pick_value(kind % 5);
    if (kind == 9) begin
      x = 0;
      y = 0;
    end
    send_point(x, y, pick_value($urandom_range(0, 4)), pick_value($urandom_range(0, 4)),
               pick_value($urandom_range(0, 4)), pick_value($urandom_range(0, 4)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_point(0, 0, 0, 5, -7, 9);
    send_point(0, 0, 0, MAX_V, MIN_V, MAX_V);
    send_point(0, 0, 65536, 65536, 65536, 65536);
    send_point(0, 0, -65536, 3, -3, -65536);
    send_point(0, 0, 1, 0, 0, MIN_V);
    send_point(1, 0, 0, MAX_V, MAX_V, MAX_V);
    send_point(65536, 0, 0, 65536, 0, 0);
    send_point(0, 65536, 0, 0, 65536, 65536);
    send_point(65536, 65536, 65536, 65536, -65536, 65536);
    send_point(MAX_V, MAX_V, MAX_V, MAX_V, MAX_V, MAX_V);
    send_point(MIN_V, MIN_V, MIN_V, MIN_V, MIN_V, MIN_V);
    send_point(MIN_V, MAX_V, MIN_V, MAX_V, MIN_V, MAX_V);
    send_point(1, 1, 1, MIN_V, MAX_V, MIN_V);
    send_point(2, 0, 0, 1, 0, 0);
    send_point(2, 0, 0, -1, 3, 0);
    send_point(3, 4, 0, 1, 1, 1);
    send_point(-3, -4, 12, -1, 2, -5);
    send_point(-1, 0, 0, 0, -1, 0);
    repeat (250) send_random();
    item_valid <= 1'b0;
    while (pending != 0 || result_valid) @(posedge clk);
    calm = 1'b1;
    repeat (200) send_random();
    calm = 1'b0;
    repeat (350) send_random();
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("cartesian_to_spherical_vector regression: pass");
    else
      $display("cartesian_to_spherical_vector regression: fail");
    $finish;
  end

endmodule

[cartesian_to_spherical_vector.f]
rtl/c2sv_pkg.sv
rtl/c2sv_sqrt.sv
rtl/c2sv_front.sv
rtl/c2sv_queue.sv
rtl/c2sv_div.sv
rtl/c2sv_back.sv
rtl/cartesian_to_spherical_vector.sv
tb/sv/c2sv_result_checker.sv
tb/sv/tb_cartesian_to_spherical_vector.sv
